// ===== hdl/csrf_pkg.sv =====
// constants, field types and frame byte helper for the checksummed register link
package csrf_pkg;

    // op codes of an input transfer
    typedef logic [1:0] op_t;
    localparam op_t OP_WRITE = 2'd0;
    localparam op_t OP_READ  = 2'd1;
    localparam op_t OP_RX    = 2'd2;

    // kind codes of a result transfer
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    // frame command codes
    localparam logic [7:0] CODE_WR_LO   = 8'h08;
    localparam logic [7:0] CODE_WR_HI   = 8'h0a;
    localparam logic [7:0] CODE_WR_ADDR = 8'h0c;
    localparam logic [7:0] CODE_RD_0    = 8'h10;
    localparam logic [7:0] CODE_RD_1    = 8'h12;
    localparam logic [7:0] CODE_RD_2    = 8'h14;
    localparam logic [7:0] CODE_MASK    = 8'h3f;
    localparam logic [7:0] CMD_FLAG     = 8'h80;

    // twelve bytes per command, three frames of four
    localparam int unsigned CMD_BYTES = 12;
    localparam logic [3:0]  LAST_IDX  = 4'(CMD_BYTES - 1);

    // payload widths
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 48;

    // byte at a given position of a frame: command, high, low, checksum
    function automatic logic [7:0] frame_byte(input logic [7:0] code,
                                              input logic [15:0] val,
                                              input logic [1:0] pos);
        logic [7:0] cb;
        logic [7:0] ck;
        logic [7:0] res;
        cb = (code & CODE_MASK) | CMD_FLAG;
        ck = ~(cb + val[15:8] + val[7:0]);
        case (pos)
            2'd0:    res = cb;
            2'd1:    res = val[15:8];
            2'd2:    res = val[7:0];
            default: res = ck;
        endcase
        return res;
    endfunction

endpackage

// ===== hdl/checksummed_spi_register_frames.sv =====
// host side of the checksummed register link: frame emitter and reply assembler
//
// channel  | dir | tdata (low bit up)                        | tuser    | tlast
// s_       | in  | reg_addr[15:0] wr_data[47:16] rx_byte[55:48] | op[1:0] | -
// m_       | out | tx_byte[7:0] read_value[39:8] check_fail[40] | kind[0] | last_byte
//
// a write or read command gives twelve link bytes, one per cycle from the output register
// while the output is not stalled; the byte counter of the emitter steps through them
// each returned byte is taken on its input transfer and the read result leaves in the
// cycle after the twelfth returned byte is taken
// synchronous active-low reset clears the emitter, reply tracking and output valid
// a stalled output holds its transfer; the input takes a new item while the last byte of
// a command is being loaded
module checksummed_spi_register_frames (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // reg_addr[15:0], wr_data[47:16], rx_byte[55:48]
    input  logic [csrf_pkg::S_TDATA_W-1:0]    s_tdata,
    // op[1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tx_byte[7:0], read_value[39:8], check_fail[40], zero fill above
    output logic [csrf_pkg::M_TDATA_W-1:0]    m_tdata,
    // kind[0]
    output logic                              m_tuser,
    output logic                              m_tlast
);

    // input field split
    logic [1:0]  in_op;
    logic [15:0] in_addr;
    logic [31:0] in_data;
    logic [7:0]  in_rx;
    assign in_op   = s_tuser;
    assign in_addr = s_tdata[15:0];
    assign in_data = s_tdata[47:16];
    assign in_rx   = s_tdata[55:48];

    // command register and emitter
    logic        busy_reg, busy_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        cmd_read_reg;
    logic [15:0] addr_reg;
    logic [31:0] data_reg;

    // reply tracking
    logic        awaiting_reg, awaiting_next;
    logic [3:0]  reply_cnt_reg, reply_cnt_next;
    logic [7:0]  status_reg, status_next;
    logic [15:0] word_reg, word_next;
    logic [15:0] low_reg, low_next;
    logic        fail_reg, fail_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  tx_reg, tx_next;
    logic        last_reg, last_next;
    logic [31:0] rv_reg, rv_next;
    logic        cf_reg, cf_next;

    logic        out_free;
    logic        emit;
    logic        in_xfer;
    logic        is_cmd;
    logic        result_fire;
    logic [7:0]  cur_code;
    logic [15:0] cur_val;
    logic [7:0]  cur_byte;
    logic [7:0]  rx_sum;
    logic        rx_bad;

    // handshake
    assign out_free = !m_valid_reg || m_tready;
    assign emit     = busy_reg && out_free;
    assign s_tready = out_free && (!busy_reg || (cnt_reg == csrf_pkg::LAST_IDX));
    assign in_xfer  = s_tvalid && s_tready;
    assign is_cmd   = (in_op == csrf_pkg::OP_WRITE) || (in_op == csrf_pkg::OP_READ);

    // byte under the emitter counter
    always_comb begin
        case ({cmd_read_reg, cnt_reg[3:2]})
            3'b000:  begin cur_code = csrf_pkg::CODE_WR_LO;   cur_val = data_reg[15:0];  end
            3'b001:  begin cur_code = csrf_pkg::CODE_WR_HI;   cur_val = data_reg[31:16]; end
            3'b010:  begin cur_code = csrf_pkg::CODE_WR_ADDR; cur_val = addr_reg;        end
            3'b100:  begin cur_code = csrf_pkg::CODE_RD_0;    cur_val = addr_reg;        end
            3'b101:  begin cur_code = csrf_pkg::CODE_RD_1;    cur_val = addr_reg;        end
            default: begin cur_code = csrf_pkg::CODE_RD_2;    cur_val = addr_reg;        end
        endcase
        cur_byte = csrf_pkg::frame_byte(cur_code, cur_val, cnt_reg[1:0]);
    end

    // checksum of the frame being received
    assign rx_sum = status_reg + word_reg[7:0] + word_reg[15:8];
    assign rx_bad = (rx_sum != ~in_rx);

    // emitter control
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (in_xfer && is_cmd) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (emit) begin
            if (cnt_reg == csrf_pkg::LAST_IDX) begin
                busy_next = 1'b0;
                cnt_next  = '0;
            end else begin
                cnt_next = cnt_reg + 4'd1;
            end
        end
    end

    // reply tracking
    always_comb begin
        awaiting_next  = awaiting_reg;
        reply_cnt_next = reply_cnt_reg;
        status_next    = status_reg;
        word_next      = word_reg;
        low_next       = low_reg;
        fail_next      = fail_reg;
        result_fire    = 1'b0;
        if (in_xfer) begin
            case (in_op)
                csrf_pkg::OP_WRITE: begin
                    awaiting_next  = 1'b0;
                    reply_cnt_next = '0;
                end
                csrf_pkg::OP_READ: begin
                    awaiting_next  = 1'b1;
                    reply_cnt_next = '0;
                    fail_next      = 1'b0;
                end
                csrf_pkg::OP_RX: begin
                    if (awaiting_reg) begin
                        reply_cnt_next = reply_cnt_reg + 4'd1;
                        case (reply_cnt_reg[1:0])
                            2'd0:    status_next = in_rx;
                            2'd1:    word_next   = {in_rx, 8'h00};
                            2'd2:    word_next   = {word_reg[15:8], in_rx};
                            default: begin
                                if (reply_cnt_reg[3:2] == 2'd1) begin
                                    low_next  = word_reg;
                                    fail_next = fail_reg | rx_bad;
                                end else if (reply_cnt_reg[3] == 1'b1) begin
                                    result_fire    = 1'b1;
                                    awaiting_next  = 1'b0;
                                    reply_cnt_next = '0;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register load: emitter byte or read result
    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        tx_next      = tx_reg;
        last_next    = last_reg;
        rv_next      = rv_reg;
        cf_next      = cf_reg;
        if (out_free) begin
            m_valid_next = emit || result_fire;
            if (emit) begin
                kind_next = csrf_pkg::KIND_TX;
                tx_next   = cur_byte;
                last_next = (cnt_reg == csrf_pkg::LAST_IDX);
                rv_next   = '0;
                cf_next   = 1'b0;
            end else begin
                kind_next = csrf_pkg::KIND_RESULT;
                tx_next   = '0;
                last_next = 1'b0;
                rv_next   = {word_reg, low_reg};
                cf_next   = fail_reg | rx_bad;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            awaiting_reg  <= 1'b0;
            reply_cnt_reg <= '0;
            status_reg    <= '0;
            word_reg      <= '0;
            low_reg       <= '0;
            fail_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            awaiting_reg  <= awaiting_next;
            reply_cnt_reg <= reply_cnt_next;
            status_reg    <= status_next;
            word_reg      <= word_next;
            low_reg       <= low_next;
            fail_reg      <= fail_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer && is_cmd) begin
            cmd_read_reg <= (in_op == csrf_pkg::OP_READ);
            addr_reg     <= in_addr;
            data_reg     <= in_data;
        end
        kind_reg <= kind_next;
        tx_reg   <= tx_next;
        last_reg <= last_next;
        rv_reg   <= rv_next;
        cf_reg   <= cf_next;
    end

    // ports
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {7'd0, cf_reg, rv_reg, tx_reg};

    // emitter counter stays within one command
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (cnt_reg <= csrf_pkg::LAST_IDX))
        else $error("emitter counter past last byte");

    // reply counter never passes the twelfth returned byte
    a_reply_range: assert property (@(posedge aclk) disable iff (!aresetn)
        reply_cnt_reg <= csrf_pkg::LAST_IDX)
        else $error("reply counter out of range");

    // a read result never competes with the emitter for the output register
    a_no_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        result_fire |-> !busy_reg)
        else $error("read result while emitter busy");

    // an accepted command starts the emitter at its first byte
    a_cmd_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && is_cmd) |=> (busy_reg && (cnt_reg == 4'd0)))
        else $error("command did not start emitter");

endmodule
